// ===== hdl/redo_log_transaction_tracker_unit_defines.svh =====
// Assertion macros used by the redo log tracker datapath.
// No dependencies; included by the files that carry checks.
`ifndef REDO_LOG_TRANSACTION_TRACKER_UNIT_DEFINES_SVH
`define REDO_LOG_TRANSACTION_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define RLTT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset
`define RLTT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RLTT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RLTT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/rltt_pkg.sv =====
// Types, codes and constants of the redo log transaction tracker.
// No dependencies; used by the controller, datapath and top level.
package rltt_pkg;

   // Table depth default
   localparam int LOG_ENTRIES_DEF = 32;

   // Fixed field widths
   localparam int BLK_W    = 32;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 4;
   localparam int OPEN_W   = 6;
   localparam int RSV_W    = 6;
   localparam int NEED_W   = 14;
   localparam int CSR_AW   = 3;

   // Open-operation ceiling
   localparam logic [OPEN_W-1:0] OPEN_MAX = 6'd63;

   // Reset value of the per-operation reserve
   localparam logic [RSV_W-1:0] RSV_RESET = 6'd10;

   // Register indexes (paddr[2])
   localparam logic REG_LOG_START  = 1'b0;
   localparam logic REG_OP_RESERVE = 1'b1;

   // Request codes
   localparam logic [1:0] REQ_BEGIN = 2'd0;
   localparam logic [1:0] REQ_END   = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED    = 4'd0,
      ST_WAIT       = 4'd1,
      ST_APPENDED   = 4'd2,
      ST_ABSORBED   = 4'd3,
      ST_COMMIT     = 4'd4,
      ST_ENDED      = 4'd5,
      ST_TOO_BIG    = 4'd6,
      ST_OUTSIDE    = 4'd7,
      ST_UNBALANCED = 4'd8
   } status_type;

   // Source of the slot field of a result
   typedef enum logic [1:0] {
      SLOT_ZERO  = 2'd0,
      SLOT_COUNT = 2'd1,
      SLOT_INDEX = 2'd2
   } slot_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic         open_inc;
      logic         open_dec;
      logic         cnt_inc;
      logic         cnt_clr;
      logic         blk_load;
      logic         ram_we;
      logic         wr_from_req;
      logic         rd_en;
      logic         rd_first;
      logic         idx_clr;
      logic         idx_inc;
      logic         out_load;
      status_type   out_status;
      slot_sel_type out_slot;
      logic         out_commit;
      logic         out_last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
      logic full;
      logic open_zero;
      logic open_one;
      logic open_max;
      logic fits;
      logic count_zero;
      logic match;
      logic at_end;
   } sts_type;

endpackage

// ===== hdl/rltt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rltt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold data when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rltt_dp.sv =====
// Datapath of the redo log tracker: counters, block table, result register.
// Depends on rltt_pkg, rltt_ram and the assertion macro header.
`include "redo_log_transaction_tracker_unit_defines.svh"

module rltt_dp #(
   parameter int LOG_ENTRIES = rltt_pkg::LOG_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rltt_pkg::cmd_type                 cmd,
   output rltt_pkg::sts_type                 sts,
   input  logic [rltt_pkg::BLK_W-1:0]        req_block_number,
   input  logic [rltt_pkg::BLK_W-1:0]        log_start_block,
   input  logic [rltt_pkg::RSV_W-1:0]        op_reserve_blocks,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rltt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [rltt_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic [rltt_pkg::BLK_W-1:0]        rsp_home_block,
   output logic [rltt_pkg::BLK_W-1:0]        rsp_log_block,
   output logic                              rsp_last
);

   localparam int IDX_W = $clog2(LOG_ENTRIES);
   localparam int CNT_W = $clog2(LOG_ENTRIES + 1);

   logic [rltt_pkg::OPEN_W-1:0]   open_ff, open_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [rltt_pkg::BLK_W-1:0]    blk_ff, blk_in;
   logic                          valid_ff, valid_in;
   rltt_pkg::status_type          status_ff, status_in;
   logic [rltt_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [rltt_pkg::BLK_W-1:0]    home_ff, home_in;
   logic [rltt_pkg::BLK_W-1:0]    logb_ff, logb_in;
   logic                          last_ff, last_in;

   logic [rltt_pkg::BLK_W-1:0]    rd_data;
   logic [rltt_pkg::BLK_W-1:0]    wr_data;
   logic [IDX_W-1:0]              wr_addr;
   logic [IDX_W-1:0]              rd_addr;
   logic [IDX_W-1:0]              slot_sel;
   logic [IDX_W+rltt_pkg::SLOT_W-1:0] slot_ext;
   logic [rltt_pkg::OPEN_W:0]     open_plus;
   logic [rltt_pkg::NEED_W-1:0]   need;

   // Block table
   assign wr_data = cmd.wr_from_req ? req_block_number : blk_ff;
   assign wr_addr = count_ff[IDX_W-1:0];
   assign rd_addr = cmd.rd_first ? '0 : idx_ff + IDX_W'(1);

   rltt_ram #(
      .WIDTH (rltt_pkg::BLK_W),
      .DEPTH (LOG_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.ram_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Admission check: count + (open + 1) * reserve against table size
   assign open_plus = {1'b0, open_ff} + (rltt_pkg::OPEN_W + 1)'(1);
   assign need = rltt_pkg::NEED_W'(count_ff)
               + rltt_pkg::NEED_W'(open_plus) * rltt_pkg::NEED_W'(op_reserve_blocks);

   // Status toward the controller
   always_comb begin
      sts.out_free   = !valid_ff || rsp_ready;
      sts.full       = (count_ff >= CNT_W'(LOG_ENTRIES));
      sts.open_zero  = (open_ff == '0);
      sts.open_one   = (open_ff == rltt_pkg::OPEN_W'(1));
      sts.open_max   = (open_ff >= rltt_pkg::OPEN_MAX);
      sts.fits       = (need <= rltt_pkg::NEED_W'(LOG_ENTRIES));
      sts.count_zero = (count_ff == '0);
      sts.match      = (rd_data == blk_ff);
      sts.at_end     = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   end

   // Slot field source, fitted to the result width
   always_comb begin
      unique case (cmd.out_slot)
         rltt_pkg::SLOT_COUNT: slot_sel = count_ff[IDX_W-1:0];
         rltt_pkg::SLOT_INDEX: slot_sel = idx_ff;
         default:              slot_sel = '0;
      endcase
      slot_ext = {{rltt_pkg::SLOT_W{1'b0}}, slot_sel};
   end

   // Next state of counters and result register
   always_comb begin
      open_in   = open_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      blk_in    = blk_ff;
      valid_in  = valid_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      home_in   = home_ff;
      logb_in   = logb_ff;
      last_in   = last_ff;

      if (cmd.open_inc) begin
         open_in = open_ff + rltt_pkg::OPEN_W'(1);
      end else if (cmd.open_dec) begin
         open_in = open_ff - rltt_pkg::OPEN_W'(1);
      end

      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.blk_load) begin
         blk_in = req_block_number;
      end

      // Drain the result register, then reload it
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         valid_in  = 1'b1;
         status_in = cmd.out_status;
         slot_in   = slot_ext[rltt_pkg::SLOT_W-1:0];
         last_in   = cmd.out_last;
         if (cmd.out_commit) begin
            home_in = rd_data;
            logb_in = log_start_block + rltt_pkg::BLK_W'(idx_ff) + rltt_pkg::BLK_W'(1);
         end else begin
            home_in = '0;
            logb_in = '0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         open_ff  <= open_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      blk_ff    <= blk_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      home_ff   <= home_in;
      logb_ff   <= logb_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_home_block = home_ff;
   assign rsp_log_block  = logb_ff;
   assign rsp_last       = last_ff;

   // Checks
   `RLTT_ASSERT_NXT(a_commit_clears, clock, reset, cmd.out_load && cmd.out_commit && cmd.out_last, count_ff == '0, "table not cleared after commit")
   `RLTT_ASSERT_IMP(a_append_room, clock, reset, cmd.ram_we, count_ff < CNT_W'(LOG_ENTRIES), "append into a full table")
   `RLTT_ASSERT_IMP(a_result_free, clock, reset, cmd.out_load, !valid_ff || rsp_ready, "result register overwritten")

endmodule

// ===== hdl/rltt_ctrl.sv =====
// Controller of the redo log tracker: request decode, table search, commit walk.
// Depends on rltt_pkg; drives the datapath through rltt_pkg::cmd_type.
module rltt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  rltt_pkg::sts_type sts,
   output rltt_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;

   // Take a request only when idle and the result register can take a result
   assign req_ready = (state_ff == S_IDLE) && sts.out_free;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.out_status = rltt_pkg::ST_GRANTED;
      cmd.out_slot   = rltt_pkg::SLOT_ZERO;
      cmd.out_last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.blk_load = 1'b1;
               unique case (req_type)
                  rltt_pkg::REQ_BEGIN: begin
                     cmd.out_load = 1'b1;
                     if (sts.open_max || !sts.fits) begin
                        cmd.out_status = rltt_pkg::ST_WAIT;
                     end else begin
                        cmd.out_status = rltt_pkg::ST_GRANTED;
                        cmd.open_inc   = 1'b1;
                     end
                  end
                  rltt_pkg::REQ_WRITE: begin
                     priority if (sts.full) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = rltt_pkg::ST_TOO_BIG;
                     end else if (sts.open_zero) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = rltt_pkg::ST_OUTSIDE;
                     end else if (sts.count_zero) begin
                        // Empty table: append at once
                        cmd.ram_we      = 1'b1;
                        cmd.wr_from_req = 1'b1;
                        cmd.cnt_inc     = 1'b1;
                        cmd.out_load    = 1'b1;
                        cmd.out_status  = rltt_pkg::ST_APPENDED;
                        cmd.out_slot    = rltt_pkg::SLOT_COUNT;
                     end else begin
                        // Start the search at slot zero
                        cmd.rd_en    = 1'b1;
                        cmd.rd_first = 1'b1;
                        cmd.idx_clr  = 1'b1;
                        state_in     = S_SEARCH;
                     end
                  end
                  rltt_pkg::REQ_END: begin
                     if (sts.open_zero) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = rltt_pkg::ST_UNBALANCED;
                     end else begin
                        cmd.open_dec = 1'b1;
                        if (!sts.open_one || sts.count_zero) begin
                           cmd.out_load   = 1'b1;
                           cmd.out_status = rltt_pkg::ST_ENDED;
                        end else begin
                           // Last operation closed: walk the table
                           cmd.rd_en    = 1'b1;
                           cmd.rd_first = 1'b1;
                           cmd.idx_clr  = 1'b1;
                           state_in     = S_COMMIT;
                        end
                     end
                  end
                  default: begin
                     // Unknown request: drop it
                  end
               endcase
            end
         end

         S_SEARCH: begin
            if (sts.out_free) begin
               priority if (sts.match) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = rltt_pkg::ST_ABSORBED;
                  cmd.out_slot   = rltt_pkg::SLOT_INDEX;
                  state_in       = S_IDLE;
               end else if (sts.at_end) begin
                  cmd.ram_we     = 1'b1;
                  cmd.cnt_inc    = 1'b1;
                  cmd.out_load   = 1'b1;
                  cmd.out_status = rltt_pkg::ST_APPENDED;
                  cmd.out_slot   = rltt_pkg::SLOT_COUNT;
                  state_in       = S_IDLE;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.idx_inc = 1'b1;
               end
            end
         end

         S_COMMIT: begin
            // Emit one entry per cycle; hold while the receiver stalls
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = rltt_pkg::ST_COMMIT;
               cmd.out_slot   = rltt_pkg::SLOT_INDEX;
               cmd.out_commit = 1'b1;
               cmd.out_last   = sts.at_end;
               if (sts.at_end) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.idx_inc = 1'b1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/redo_log_transaction_tracker_unit.sv =====
// Top level of the redo log transaction tracker: CSR block and core wiring.
// Depends on rltt_pkg, rltt_ctrl and rltt_dp.
//
// Usage:
//   Requests (req_type, req_block_number) enter on a valid/ready channel:
//   begin, end, or write of a home block number. Results leave on a
//   valid/ready channel; rsp_last marks the final result of a request.
//   Begin, an end that starts no commit walk and a write that starts no
//   search give one result in the cycle after acceptance. A write into a
//   table of N entries searches one slot a cycle through the table RAM's
//   single read port. An end that closes the last operation emits N
//   commit entries, one per cycle while the receiver does not stall.
//   A new request is taken once the previous one is finished and the
//   result register is empty or being drained in that cycle.
//   When the receiver stalls, the result register holds and the walk pauses.
//   Reset clears the open count, entry count and result valid; the CSRs
//   return to log_start_block = 0 and op_reserve_blocks = 10. The table
//   needs no clearing pass. CSRs at 0x0 and 0x4; write only while idle.
module redo_log_transaction_tracker_unit #(
   parameter int LOG_ENTRIES = rltt_pkg::LOG_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_type,
   input  logic [rltt_pkg::BLK_W-1:0]        req_block_number,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rltt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [rltt_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic [rltt_pkg::BLK_W-1:0]        rsp_home_block,
   output logic [rltt_pkg::BLK_W-1:0]        rsp_log_block,
   output logic                              rsp_last,
   // CSR port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rltt_pkg::CSR_AW-1:0]       paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   logic [rltt_pkg::BLK_W-1:0] log_start_ff, log_start_in;
   logic [rltt_pkg::RSV_W-1:0] reserve_ff, reserve_in;
   logic                       csr_wr;
   rltt_pkg::cmd_type          cmd;
   rltt_pkg::sts_type          sts;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   // Register writes
   always_comb begin
      log_start_in = log_start_ff;
      reserve_in   = reserve_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            rltt_pkg::REG_LOG_START:  log_start_in = pwdata;
            rltt_pkg::REG_OP_RESERVE: reserve_in   = pwdata[rltt_pkg::RSV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_start_ff <= '0;
         reserve_ff   <= rltt_pkg::RSV_RESET;
      end else begin
         log_start_ff <= log_start_in;
         reserve_ff   <= reserve_in;
      end
   end

   // Register reads
   always_comb begin
      unique case (paddr[2])
         rltt_pkg::REG_LOG_START:  prdata = log_start_ff;
         rltt_pkg::REG_OP_RESERVE: prdata = 32'(reserve_ff);
         default:                  prdata = '0;
      endcase
   end

   rltt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .sts       (sts),
      .cmd       (cmd)
   );

   rltt_dp #(
      .LOG_ENTRIES (LOG_ENTRIES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_block_number  (req_block_number),
      .log_start_block   (log_start_ff),
      .op_reserve_blocks (reserve_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_home_block    (rsp_home_block),
      .rsp_log_block     (rsp_log_block),
      .rsp_last          (rsp_last)
   );

endmodule
